// ===== rtl/mrfd_pkg.sv =====
// Modbus RTU frame decoder: shared types, codes and the CRC-16 byte step.
// Used by every module of the decoder; no dependencies.
`default_nettype none

package mrfd_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam int unsigned HDR_LEN = 6;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_QUANTITY = 2'd1;
   localparam logic [1:0] KIND_VALUE    = 2'd2;

   localparam logic [7:0] FC_READ_COILS      = 8'h01;
   localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
   localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
   localparam logic [7:0] FC_WRITE_REG       = 8'h06;
   localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
   localparam logic [7:0] FC_WRITE_REGS      = 8'h10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  node_addr;
      logic [7:0]  func_code;
      logic        exc_flag;
      logic [7:0]  exc_code;
      logic [1:0]  field_kind;
      logic [15:0] addr_word;
      logic [15:0] second_word;
      logic [15:0] computed_crc;
      logic [15:0] received_crc;
      logic [8:0]  frame_length;
   } rsp_type;

   // One finished frame, handed from the front to the back.
   typedef struct packed {
      logic                     too_short;
      logic                     has_words;
      logic [8:0]               frame_length;
      logic [HDR_LEN-1:0][7:0]  header;
      logic [15:0]              computed_crc;
      logic [15:0]              received_crc;
   } frame_rec_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/modbus_rtu_frame_decoder_core.sv =====
// Modbus RTU frame decoder top level: front, two-entry frame queue and back.
// Uses mrfd_pkg, mrfd_front, mrfd_queue and mrfd_back.
//
// Takes one frame byte per cycle unless stalled, with last_byte marking the
// end of a frame, and gives one result per frame: status (ok, too short, CRC
// mismatch), address, function code, exception code and decoded word pair, both
// CRC values and the byte count saturated at MAX_FRAME_BYTES. The CRC-16 byte
// step is unrolled in the front, so bytes stream at one per cycle unless
// stalled. The back registers the result as it pops the frame. A two-entry
// frame queue sits between front and back; req_stall rises only while both
// entries are held because rsp_stall keeps the output register from draining.
`default_nettype none

module modbus_rtu_frame_decoder_core
   import mrfd_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_payload,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);

   logic             accept;
   logic             push;
   logic             pop;
   frame_rec_type    front_frame;
   frame_rec_type    head_frame;
   queue_ctl_type    queue_ctl;
   queue_status_type queue_status;

   assign req_stall = queue_status.full;
   assign accept    = req_valid & ~queue_status.full;

   mrfd_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_payload),
      .push  (push),
      .frame (front_frame)
   );

   assign queue_ctl.push = push;
   assign queue_ctl.pop  = pop;

   mrfd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctl     (queue_ctl),
      .wr_frame(front_frame),
      .rd_frame(head_frame),
      .status  (queue_status)
   );

   mrfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .frame_ready(~queue_status.empty),
      .frame      (head_frame),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/mrfd_front.sv =====
// Modbus RTU decoder front: takes bytes, runs the CRC behind a two-byte delay,
// captures the header and pushes one frame record at the last byte. Uses mrfd_pkg.
`default_nettype none

module mrfd_front
   import mrfd_pkg::*;
#(
   parameter int unsigned MAX_FRAME_BYTES = 256
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      accept,
   input  wire req_type   req,
   output logic           push,
   output frame_rec_type  frame
);

   localparam int unsigned CountWidth = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_FRAME_BYTES);

   logic [15:0]             crc_ff, crc_in, crc_now;
   logic [7:0]              dly0_ff, dly0_in;
   logic [7:0]              dly1_ff, dly1_in;
   logic [1:0]              fill_ff, fill_in;
   logic [CountWidth-1:0]   cnt_ff, cnt_in, length_now;
   logic [HDR_LEN-1:0][7:0] hdr_ff, hdr_in, hdr_now;

   always_comb begin
      crc_now = fill_ff[1] ? crc_feed(crc_ff, dly1_ff) : crc_ff;
      hdr_now = hdr_ff;
      if (cnt_ff < CountWidth'(HDR_LEN)) begin
         hdr_now[cnt_ff[2:0]] = req.data_byte;
      end
      length_now = (cnt_ff >= MaxCount) ? MaxCount : cnt_ff + 1'b1;
   end

   always_comb begin
      crc_in  = crc_ff;
      dly0_in = dly0_ff;
      dly1_in = dly1_ff;
      fill_in = fill_ff;
      cnt_in  = cnt_ff;
      hdr_in  = hdr_ff;
      if (accept) begin
         if (req.last_byte) begin
            crc_in  = CRC_INIT;
            dly0_in = '0;
            dly1_in = '0;
            fill_in = '0;
            cnt_in  = '0;
            hdr_in  = '0;
         end else begin
            crc_in  = crc_now;
            dly0_in = req.data_byte;
            dly1_in = dly0_ff;
            fill_in = fill_ff[1] ? fill_ff : fill_ff + 1'b1;
            cnt_in  = (cnt_ff < MaxCount) ? cnt_ff + 1'b1 : cnt_ff;
            hdr_in  = hdr_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         dly0_ff <= '0;
         dly1_ff <= '0;
         fill_ff <= '0;
         cnt_ff  <= '0;
         hdr_ff  <= '0;
      end else begin
         crc_ff  <= crc_in;
         dly0_ff <= dly0_in;
         dly1_ff <= dly1_in;
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
         hdr_ff  <= hdr_in;
      end
   end

   assign push = accept & req.last_byte;

   always_comb begin
      frame.too_short    = (cnt_ff < CountWidth'(3));
      frame.has_words    = (cnt_ff >= CountWidth'(7));
      frame.frame_length = 9'(length_now);
      frame.header       = hdr_now;
      frame.computed_crc = crc_now;
      frame.received_crc = {req.data_byte, dly0_ff};
   end

endmodule

`default_nettype wire

// ===== rtl/mrfd_queue.sv =====
// Two-entry frame queue between the decoder front and back.
// Uses mrfd_pkg for the frame record and control structs.
`default_nettype none

module mrfd_queue
   import mrfd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_ctl_type  ctl,
   input  wire frame_rec_type  wr_frame,
   output frame_rec_type       rd_frame,
   output queue_status_type    status
);

   frame_rec_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = ctl.push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = ctl.pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!ctl.push && ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[wr_ptr_ff] <= wr_frame;
      end
   end

   assign rd_frame     = entry_ff[rd_ptr_ff];
   assign status.full  = count_ff[1];
   assign status.empty = (count_ff == 2'd0);

endmodule

`default_nettype wire

// ===== rtl/mrfd_back.sv =====
// Modbus RTU decoder back: checks the CRC, classifies the function code and
// holds the result in the output register. Uses mrfd_pkg.
`default_nettype none

module mrfd_back
   import mrfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          frame_ready,
   input  wire frame_rec_type frame,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_payload
);

   logic    valid_ff, valid_in;
   rsp_type result_ff, result_now;
   logic [7:0] fc;

   assign fc = frame.header[1];

   always_comb begin
      result_now              = '0;
      result_now.frame_length = frame.frame_length;
      if (frame.too_short) begin
         result_now.status = STATUS_SHORT;
      end else begin
         result_now.node_addr    = frame.header[0];
         result_now.func_code    = fc;
         result_now.computed_crc = frame.computed_crc;
         result_now.received_crc = frame.received_crc;
         if (frame.computed_crc != frame.received_crc) begin
            result_now.status = STATUS_MISMATCH;
         end else if (fc[7]) begin
            result_now.exc_flag = 1'b1;
            result_now.exc_code = frame.header[2];
         end else if (frame.has_words) begin
            if ((fc >= FC_READ_COILS && fc <= FC_READ_INPUT_REGS) ||
                fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
               result_now.field_kind = KIND_QUANTITY;
            end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG) begin
               result_now.field_kind = KIND_VALUE;
            end
            if (result_now.field_kind != KIND_NONE) begin
               result_now.addr_word   = {frame.header[2], frame.header[3]};
               result_now.second_word = {frame.header[4], frame.header[5]};
            end
         end
      end
   end

   assign pop = frame_ready & (~valid_ff | ~rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_now;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = result_ff;

endmodule

`default_nettype wire

// ===== tb/mrfd_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Frame decode predictor and scoreboard for the Modbus RTU frame decoder testbench.
// Depends on mrfd_pkg for the request/response types, status codes and function codes.
package mrfd_scoreboard_pkg;
   import mrfd_pkg::*;

   localparam int unsigned MAX_FRAME = 256;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      repeat (8) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   class mrfd_scoreboard;
      rsp_type     expected_decodes[$];
      logic [15:0] crc_acc;
      logic [7:0]  newest;
      logic [7:0]  older;
      int          fill;
      int          count;
      logic [7:0]  header[HDR_LEN];
      int          errors;
      int          decodes_checked;
      int          n_short;
      int          n_bad_crc;
      int          n_exception;
      int          n_words;

      function new();
         restart_frame();
      endfunction

      function void restart_frame();
         crc_acc = CRC_INIT;
         newest = 8'h00;
         older = 8'h00;
         fill = 0;
         count = 0;
         foreach (header[i]) header[i] = 8'h00;
      endfunction

      function void take_byte(input req_type item);
         rsp_type          exp;
         logic [7:0]       prev;
         logic [7:0]       fc;
         logic [15:0]      rcvd;
         logic [1:0]       kind;
         int unsigned      total;
         prev = newest;
         if (fill >= 2) crc_acc = crc16_byte(crc_acc, older);
         if (count < HDR_LEN) header[count] = item.data_byte;
         if (!item.last_byte) begin
            older = newest;
            newest = item.data_byte;
            if (fill < 2) fill++;
            if (count < MAX_FRAME) count++;
            return;
         end
         total = count + 1;
         exp = '0;
         exp.status = STATUS_OK;
         exp.frame_length = 9'((total > MAX_FRAME) ? MAX_FRAME : total);
         if (total < 4) begin
            exp.status = STATUS_SHORT;
            n_short++;
         end else begin
            rcvd = {item.data_byte, prev};
            fc = header[1];
            exp.node_addr = header[0];
            exp.func_code = fc;
            exp.computed_crc = crc_acc;
            exp.received_crc = rcvd;
            if (crc_acc != rcvd) begin
               exp.status = STATUS_MISMATCH;
               n_bad_crc++;
            end else if (fc[7]) begin
               exp.exc_flag = 1'b1;
               exp.exc_code = header[2];
               n_exception++;
            end else if (total >= 8) begin
               if ((fc >= FC_READ_COILS && fc <= FC_READ_INPUT_REGS) ||
                   fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
                  kind = KIND_QUANTITY;
               end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG) begin
                  kind = KIND_VALUE;
               end else begin
                  kind = KIND_NONE;
               end
               if (kind != KIND_NONE) begin
                  exp.field_kind = kind;
                  exp.addr_word = {header[2], header[3]};
                  exp.second_word = {header[4], header[5]};
                  n_words++;
               end
            end
         end
         expected_decodes.push_back(exp);
         restart_frame();
      endfunction

      function void compare(input string field, input logic [15:0] want,
                            input logic [15:0] seen);
         if (seen !== want) begin
            $error("%s: expected %h, got %h", field, want, seen);
            errors++;
         end
      endfunction

      function void check_decode(input rsp_type got);
         rsp_type exp;
         if (expected_decodes.size() == 0) begin
            $error("decode result with none pending: %h", got);
            errors++;
            return;
         end
         exp = expected_decodes.pop_front();
         decodes_checked++;
         compare("status", 16'(exp.status), 16'(got.status));
         compare("node_addr", 16'(exp.node_addr), 16'(got.node_addr));
         compare("func_code", 16'(exp.func_code), 16'(got.func_code));
         compare("exc_flag", 16'(exp.exc_flag), 16'(got.exc_flag));
         compare("exc_code", 16'(exp.exc_code), 16'(got.exc_code));
         compare("field_kind", 16'(exp.field_kind), 16'(got.field_kind));
         compare("addr_word", exp.addr_word, got.addr_word);
         compare("second_word", exp.second_word, got.second_word);
         compare("computed_crc", exp.computed_crc, got.computed_crc);
         compare("received_crc", exp.received_crc, got.received_crc);
         compare("frame_length", 16'(exp.frame_length), 16'(got.frame_length));
      endfunction
   endclass

endpackage

// ===== tb/tb_modbus_rtu_frame_decoder_core.sv =====
`timescale 1ns / 100ps
// Top-level testbench for modbus_rtu_frame_decoder_core: directed and random RTU frames.
// Depends on mrfd_pkg, mrfd_scoreboard_pkg and the decoder RTL.
module tb_modbus_rtu_frame_decoder_core;
   import mrfd_pkg::*;
   import mrfd_scoreboard_pkg::*;

   localparam int unsigned REQUEST_COUNT = 1050;
   localparam logic [7:0] FC_READ_DISCRETE     = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING_REGS = 8'h03;
   localparam logic [7:0] EXCEPTION_FLAG       = 8'h80;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   mrfd_scoreboard sb = new();
   int             requests_sent;

   modbus_rtu_frame_decoder_core #(
      .MAX_FRAME_BYTES(MAX_FRAME)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.take_byte(req_payload);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_decode(rsp_payload);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] pick_function_code();
      logic [7:0] codes[8];
      int         r;
      codes = '{FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING_REGS, FC_READ_INPUT_REGS,
                FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS};
      r = $urandom_range(0, 99);
      if (r < 60) return codes[$urandom_range(0, 7)];
      if (r < 80) return codes[$urandom_range(0, 7)] | EXCEPTION_FLAG;
      return rand_byte();
   endfunction

   function automatic void append_crc(ref logic [7:0] frame[$], input bit corrupt);
      logic [15:0] crc;
      crc = CRC_INIT;
      foreach (frame[i]) crc = crc16_byte(crc, frame[i]);
      if (corrupt) crc ^= 16'($urandom_range(1, 65535));
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
   endfunction

   task automatic send_byte(input logic [7:0] data, input bit last, input bit calm);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{data_byte: data, last_byte: last};
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic send_frame(input logic [7:0] frame[$], input bit calm);
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1, calm);
   endtask

   // hold off once for a long stretch so the frame queue fills and stalls the input
   initial begin
      int gap;
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      wait (!reset);
      forever begin
         if (!hold_done && sb.decodes_checked >= 30) begin
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
            hold_done = 1'b1;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      logic [7:0] frame[$];
      int         len;
      int         pick;
      int         frame_no;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      frame = {8'hFF};
      send_frame(frame, 1'b0);
      frame = {8'h00, 8'hFF, 8'h80};
      send_frame(frame, 1'b0);
      frame = {8'h11, FC_READ_INPUT_REGS | EXCEPTION_FLAG};
      append_crc(frame, 1'b0);
      send_frame(frame, 1'b0);
      frame = {8'hFF, FC_WRITE_REG, 8'h00, 8'h00, 8'hFF, 8'hFF};
      append_crc(frame, 1'b0);
      send_frame(frame, 1'b1);
      frame = {8'h00, FC_WRITE_REGS, 8'hFF, 8'hFF, 8'h00, 8'h00};
      append_crc(frame, 1'b1);
      send_frame(frame, 1'b0);

      frame_no = 0;
      while (requests_sent < REQUEST_COUNT) begin
         frame.delete();
         pick = $urandom_range(0, 99);
         if (frame_no == 10 || frame_no == 40) begin
            len = (frame_no == 10) ? MAX_FRAME : $urandom_range(MAX_FRAME + 1, MAX_FRAME + 40);
            repeat (len - 2) frame.push_back(rand_byte());
            append_crc(frame, 1'b0);
         end else if (pick < 8) begin
            repeat ($urandom_range(1, 3)) frame.push_back(rand_byte());
         end else if (pick < 15) begin
            repeat ($urandom_range(4, 12)) frame.push_back(rand_byte());
         end else begin
            frame.push_back(rand_byte());
            frame.push_back(pick_function_code());
            len = ($urandom_range(0, 99) < 70) ? 4 : $urandom_range(0, 10);
            repeat (len) frame.push_back(rand_byte());
            append_crc(frame, $urandom_range(0, 9) == 0);
         end
         send_frame(frame, $urandom_range(0, 4) == 0);
         frame_no++;
      end
      req_valid <= 1'b0;

      while (sb.expected_decodes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d random frames plus directed ones; checked %0d decodes",
               requests_sent, frame_no, sb.decodes_checked);
      $display("Too short %0d, CRC mismatch %0d, exception %0d, decoded word pairs %0d",
               sb.n_short, sb.n_bad_crc, sb.n_exception, sb.n_words);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
